// ===== rtl/core/alds_pkg.sv =====
package alds_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [1:0] CFG_VTOTAL = 2'd0;
    localparam logic [1:0] CFG_VBLANK = 2'd1;
    localparam logic [1:0] CFG_VSYNC  = 2'd2;
    localparam logic [1:0] CFG_SINGLE = 2'd3;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] scanline;
        logic        sense;
    } t_alds_in;

    typedef struct packed {
        logic        kind;
        logic        connected;
        logic        blank_rewritten;
        logic [31:0] new_blank_word;
        logic [15:0] sample_line;
        logic [15:0] samples_seen;
        logic [15:0] samples_sensed;
    } t_alds_out;

    typedef struct packed {
        logic        rewritten;
        logic [31:0] word;
        logic [15:0] sample_line;
        logic [11:0] active_lines;
    } t_alds_start;

    function automatic logic [15:0] cnt_to16(input logic [COUNT_WIDTH-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[15:0];
    endfunction

endpackage

// ===== rtl/core/alds_start.sv =====
module alds_start (
    input  logic [31:0]          i_vtotal_word,
    input  logic [31:0]          i_vblank_word,
    input  logic [31:0]          i_vsync_word,
    input  logic                 i_single,
    output alds_pkg::t_alds_start o_start
);
    import alds_pkg::*;

    logic [12:0] vtotal;
    logic [11:0] vactive;
    logic [12:0] bstart_raw;
    logic [12:0] bend;
    logic [16:0] bstart;
    logic        no_border;
    logic [31:0] diff_top;
    logic [31:0] diff_bot;
    logic [17:0] sum_top;
    logic [17:0] sum_bot;
    logic [15:0] vsample;

    assign vtotal     = {1'b0, i_vtotal_word[27:16]} + 13'd1;
    assign vactive    = {1'b0, i_vtotal_word[10:0]} + 12'd1;
    assign bstart_raw = {1'b0, i_vblank_word[11:0]} + 13'd1;
    assign bend       = {1'b0, i_vblank_word[27:16]} + 13'd1;

    assign no_border = ({1'b0, bstart_raw} <= {1'b0, vactive}) && (bend >= vtotal);

    // no vertical border: blanking starts at sync start
    assign bstart = no_border ? ({1'b0, i_vsync_word[15:0]} + 17'd1)
                              : {4'd0, bstart_raw};

    assign diff_top = 32'(bstart) - 32'(vactive);
    assign diff_bot = 32'(vtotal) - 32'(bend);
    assign sum_top  = 18'(bstart) + 18'(vactive);
    assign sum_bot  = 18'(vtotal) + 18'(bend);
    assign vsample  = (diff_top >= diff_bot) ? sum_top[16:1] : sum_bot[16:1];

    always_comb begin
        o_start.active_lines = vactive;
        if (i_single) begin
            o_start.rewritten   = 1'b0;
            o_start.word        = 32'd0;
            o_start.sample_line = 16'd0;
        end else begin
            o_start.rewritten   = no_border;
            o_start.word        = no_border ? {4'd0, i_vblank_word[27:16], i_vsync_word[15:0]}
                                            : 32'd0;
            o_start.sample_line = vsample;
        end
    end

endmodule

// ===== rtl/core/alds_ctrl.sv =====
module alds_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  alds_pkg::t_alds_in    i_item,
    input  alds_pkg::t_alds_start i_start,
    input  logic                  i_single,
    output logic                  o_res_valid,
    output alds_pkg::t_alds_out   o_res
);
    import alds_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_BELOW,
        PH_PAST,
        PH_COUNT
    } t_phase;

    t_phase                 r_phase,  n_phase;
    logic [11:0]            r_active, n_active;
    logic [15:0]            r_thresh, n_thresh;
    logic [15:0]            r_latch,  n_latch;
    logic [COUNT_WIDTH-1:0] r_total,  n_total;
    logic [COUNT_WIDTH-1:0] r_sensed, n_sensed;

    logic [COUNT_WIDTH-1:0] inc_total;
    logic [COUNT_WIDTH-1:0] inc_sensed;
    logic [COUNT_WIDTH+1:0] sensed_x4;
    logic [COUNT_WIDTH+1:0] total_x3;

    assign inc_total  = (r_total != CNT_MAX) ? r_total + 1'b1 : r_total;
    assign inc_sensed = (i_item.sense && (r_sensed != CNT_MAX)) ? r_sensed + 1'b1 : r_sensed;
    assign sensed_x4  = {inc_sensed, 2'b00};
    assign total_x3   = {2'b00, inc_total} + {1'b0, inc_total, 1'b0};

    always_comb begin
        n_phase     = r_phase;
        n_active    = r_active;
        n_thresh    = r_thresh;
        n_latch     = r_latch;
        n_total     = r_total;
        n_sensed    = r_sensed;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_fire) begin
            if (i_item.op == OP_START) begin
                n_total                 = '0;
                n_sensed                = '0;
                n_latch                 = 16'd0;
                n_active                = i_start.active_lines;
                n_thresh                = i_start.sample_line;
                n_phase                 = i_single ? PH_SINGLE : PH_BELOW;
                o_res_valid             = 1'b1;
                o_res.kind              = KIND_REPORT;
                o_res.blank_rewritten   = i_start.rewritten;
                o_res.new_blank_word    = i_start.word;
                o_res.sample_line       = i_start.sample_line;
            end else begin
                case (r_phase)
                    PH_SINGLE: begin
                        n_phase              = PH_IDLE;
                        n_total              = COUNT_WIDTH'(1);
                        n_sensed             = COUNT_WIDTH'(i_item.sense);
                        o_res_valid          = 1'b1;
                        o_res.kind           = KIND_VERDICT;
                        o_res.connected      = i_item.sense;
                        o_res.samples_seen   = 16'd1;
                        o_res.samples_sensed = {15'd0, i_item.sense};
                    end
                    PH_BELOW: begin
                        if (i_item.scanline < {4'd0, r_active}) begin
                            n_phase = PH_PAST;
                        end
                    end
                    PH_PAST: begin
                        if (i_item.scanline > r_thresh) begin
                            n_latch  = i_item.scanline;
                            n_total  = '0;
                            n_sensed = '0;
                            n_phase  = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        n_total  = inc_total;
                        n_sensed = inc_sensed;
                        if (i_item.scanline != r_latch) begin
                            n_phase              = PH_IDLE;
                            o_res_valid          = 1'b1;
                            o_res.kind           = KIND_VERDICT;
                            o_res.connected      = sensed_x4 > total_x3;
                            o_res.sample_line    = r_thresh;
                            o_res.samples_seen   = cnt_to16(inc_total);
                            o_res.samples_sensed = cnt_to16(inc_sensed);
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_active <= 12'd0;
            r_thresh <= 16'd0;
            r_latch  <= 16'd0;
            r_total  <= '0;
            r_sensed <= '0;
        end else begin
            r_phase  <= n_phase;
            r_active <= n_active;
            r_thresh <= n_thresh;
            r_latch  <= n_latch;
            r_total  <= n_total;
            r_sensed <= n_sensed;
        end
    end

endmodule

// ===== rtl/core/analog_load_detect_sampler.sv =====
// analog load-detect sampler
// input channel: i_in_valid / o_in_stall carry one item (op, scanline, sense);
// an item is taken at a clock edge where i_in_valid is high and o_in_stall low.
// op start unpacks the vertical timing registers and answers with a start
// report; op sample feeds the scanline vote and answers only with the verdict.
// output channel: o_out_valid / i_out_stall; a result leaves at an edge where
// o_out_valid is high and i_out_stall low.
// configuration: i_cfg_valid / o_cfg_ready with index and data; ready is
// always high, writes take effect at the next start item.
// an item taken goes to the input register, which feeds the result register.
// throughput: one item per cycle while the skid register is empty.
// a stalled result is parked in a one-entry skid register; o_in_stall rises
// only while the skid register and the input register are both full.
// reset (synchronous, active low) clears the configuration registers, the phase to idle,
// the counters and all valid flags.
module analog_load_detect_sampler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  alds_pkg::t_alds_in  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output alds_pkg::t_alds_out o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import alds_pkg::*;

    logic [31:0] r_vtotal;
    logic [31:0] r_vblank;
    logic [31:0] r_vsync;
    logic        r_single;

    logic        r_in_vld;
    t_alds_in    r_in;
    logic        r_out_vld;
    t_alds_out   r_out;
    logic        r_skid_vld;
    t_alds_out   r_skid;

    logic        proc_fire;
    logic        in_take;
    logic        out_free;
    logic        res_valid;
    t_alds_out   res;
    t_alds_start start_info;

    assign o_cfg_ready = 1'b1;
    assign proc_fire   = r_in_vld && !r_skid_vld;
    assign o_in_stall  = r_in_vld && r_skid_vld;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    alds_start u_start (
        .i_vtotal_word (r_vtotal),
        .i_vblank_word (r_vblank),
        .i_vsync_word  (r_vsync),
        .i_single      (r_single),
        .o_start       (start_info)
    );

    alds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc_fire),
        .i_item      (r_in),
        .i_start     (start_info),
        .i_single    (r_single),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtotal <= 32'd0;
            r_vblank <= 32'd0;
            r_vsync  <= 32'd0;
            r_single <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VTOTAL: r_vtotal <= i_cfg_data;
                CFG_VBLANK: r_vblank <= i_cfg_data;
                CFG_VSYNC:  r_vsync  <= i_cfg_data;
                CFG_SINGLE: r_single <= i_cfg_data[0];
                default:    r_single <= r_single;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (proc_fire) begin
            r_in_vld <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // result register with a one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_vld <= 1'b1;
        end
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

endmodule
